/* design/assert_macros.svh */
// Assertion helpers shared by the mesh generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CMG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CMG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cmg_pkg.sv */
`default_nettype none

package cmg_pkg;

   localparam int MAX_RINGS        = 1024;
   localparam int MAX_SLICES       = 1024;
   localparam int SINE_TABLE_DEPTH = 256;

   localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_SHIFT = 14 - SINE_IDX_W;
   localparam int RING_W     = $clog2(MAX_RINGS) + 1;
   localparam int SLICE_W    = $clog2(MAX_SLICES) + 1;
   localparam int IDX_W      = 21;
   localparam int ONE_Q14    = 16384;

   typedef enum logic [2:0] {
      SEC_SIDE_V = 3'd0,
      SEC_SIDE_T = 3'd1,
      SEC_TOP_V  = 3'd2,
      SEC_TOP_T  = 3'd3,
      SEC_BOT_V  = 3'd4,
      SEC_BOT_T  = 3'd5,
      SEC_DONE   = 3'd6
   } section_type;

   typedef enum logic [2:0] {
      KIND_SIDE_VTX = 3'd0,
      KIND_TOP_VTX  = 3'd1,
      KIND_BOT_VTX  = 3'd2,
      KIND_SIDE_TRI = 3'd3,
      KIND_CAP_TRI  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CSR_RADIUS      = 3'd0,
      CSR_HALF_LENGTH = 3'd1,
      CSR_RING_STEP   = 3'd2,
      CSR_ANGLE_STEP  = 3'd3,
      CSR_RING_COUNT  = 3'd4,
      CSR_SLICE_COUNT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [15:0] radius;
      logic [14:0] half_length;
      logic [14:0] ring_step;
      logic [15:0] angle_step;
      logic [10:0] ring_count;
      logic [10:0] slice_count;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic               rim;
      logic               radial;
      logic signed [15:0] y;
      logic signed [15:0] ny;
      logic signed [15:0] cosv;
      logic signed [15:0] sinv;
      logic [IDX_W-1:0]   ia;
      logic [IDX_W-1:0]   ib;
      logic [IDX_W-1:0]   ic;
      logic               last;
   } elem_type;

   typedef logic [14:0] sine_tab_type [SINE_TABLE_DEPTH+1];

   // Restoring long division; only evaluated while the table is built.
   function automatic longint unsigned udiv_const(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Q1.14 sin(pi/2 * k / depth) by integer Taylor series in Q30.
   function automatic logic [14:0] quarter_sine(int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned sum;
      longint unsigned term;
      longint unsigned q;
      x    = (64'd1686629713 * longint'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      for (int n = 1; n <= 12; n++) begin
         term = udiv_const((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
         if (n % 2 == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      q = (sum + 64'd32768) >> 16;
      if (q > 64'd16384) begin
         q = 64'd16384;
      end
      return q[14:0];
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type t;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         t[k] = quarter_sine(k);
      end
      return t;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   function automatic logic signed [15:0] sine_of(logic [15:0] p);
      logic [1:0]            quad;
      logic [SINE_IDX_W-1:0] i;
      logic [SINE_IDX_W:0]   k;
      logic [14:0]           v;
      quad = p[15:14];
      i    = p[13:SINE_SHIFT];
      k    = quad[0] ? ((SINE_IDX_W+1)'(SINE_TABLE_DEPTH) - {1'b0, i}) : {1'b0, i};
      v    = SINE_TAB[k];
      return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

endpackage

`default_nettype wire

/* design/cmg_req_if.sv */
`default_nettype none

interface cmg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

/* design/cmg_rsp_if.sv */
`default_nettype none

interface cmg_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         element_kind;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic [20:0]        index_a;
   logic [20:0]        index_b;
   logic [20:0]        index_c;
   logic               last;

   modport source (output valid, output element_kind, output pos_x, output pos_y,
                   output pos_z, output norm_x, output norm_y, output norm_z,
                   output index_a, output index_b, output index_c, output last,
                   input ready);
   modport sink (input valid, input element_kind, input pos_x, input pos_y,
                 input pos_z, input norm_x, input norm_y, input norm_z,
                 input index_a, input index_b, input index_c, input last,
                 output ready);
endinterface

`default_nettype wire

/* design/cmg_csr.sv */
`default_nettype none

module cmg_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_wdata,
   output cmg_pkg::cfg_type      cfg
);

   cmg_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius      <= 16'd256;
         cfg_ff.half_length <= 15'd256;
         cfg_ff.ring_step   <= 15'd57;
         cfg_ff.angle_step  <= 16'd2185;
         cfg_ff.ring_count  <= 11'd10;
         cfg_ff.slice_count <= 11'd30;
      end else if (csr_we) begin
         case (csr_index)
            cmg_pkg::CSR_RADIUS:      cfg_ff.radius      <= csr_wdata;
            cmg_pkg::CSR_HALF_LENGTH: cfg_ff.half_length <= csr_wdata[14:0];
            cmg_pkg::CSR_RING_STEP:   cfg_ff.ring_step   <= csr_wdata[14:0];
            cmg_pkg::CSR_ANGLE_STEP:  cfg_ff.angle_step  <= csr_wdata;
            cmg_pkg::CSR_RING_COUNT:  cfg_ff.ring_count  <= csr_wdata[10:0];
            cmg_pkg::CSR_SLICE_COUNT: cfg_ff.slice_count <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/cmg_sequencer.sv */
`default_nettype none

`include "assert_macros.svh"

module cmg_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmg_pkg::cfg_type cfg,
   cmg_req_if.sink          req,
   input  wire logic        stage_ready,
   output logic             stage_valid,
   output cmg_pkg::elem_type stage_elem
);

   cmg_pkg::section_type              section_ff, section_in;
   logic [cmg_pkg::RING_W-1:0]        ring_ff, ring_in;
   logic [cmg_pkg::SLICE_W-1:0]       slice_ff, slice_in;
   logic                              second_ff, second_in;
   logic [15:0]                       phase_ff, phase_in;
   logic signed [15:0]                height_ff, height_in;
   logic [cmg_pkg::IDX_W-1:0]         vcount_ff, vcount_in;
   logic [cmg_pkg::IDX_W-1:0]         center_ff, center_in;
   logic                              valid_ff;
   cmg_pkg::elem_type                 elem_ff, elem_in;

   logic                              accept;
   logic                              emit;
   logic [15:0]                       emit_phase;
   logic [cmg_pkg::RING_W-1:0]        rings;
   logic [cmg_pkg::SLICE_W-1:0]       slices;
   logic signed [15:0]                neg_hl;
   logic signed [15:0]                pos_hl;
   logic signed [16:0]                hsum;
   logic [cmg_pkg::IDX_W-1:0]         ring_x, slc1_x, j_x, rs, nrs;

   assign req.ready = !valid_ff || stage_ready;
   assign accept    = req.valid && req.ready;

   assign rings  = (cfg.ring_count < 11'd2) ? cmg_pkg::RING_W'(2) :
                   (32'(cfg.ring_count) > cmg_pkg::MAX_RINGS) ?
                   cmg_pkg::RING_W'(cmg_pkg::MAX_RINGS) : cmg_pkg::RING_W'(cfg.ring_count);
   assign slices = (cfg.slice_count < 11'd3) ? cmg_pkg::SLICE_W'(3) :
                   (32'(cfg.slice_count) > cmg_pkg::MAX_SLICES) ?
                   cmg_pkg::SLICE_W'(cmg_pkg::MAX_SLICES) : cmg_pkg::SLICE_W'(cfg.slice_count);
   assign neg_hl = -$signed({1'b0, cfg.half_length});
   assign pos_hl = $signed({1'b0, cfg.half_length});

   always_comb begin
      // restart rewinds the pass before this word is worked on
      section_in = req.restart ? cmg_pkg::SEC_SIDE_V : section_ff;
      ring_in    = req.restart ? '0 : ring_ff;
      slice_in   = req.restart ? '0 : slice_ff;
      second_in  = req.restart ? 1'b0 : second_ff;
      phase_in   = req.restart ? 16'd0 : phase_ff;
      height_in  = req.restart ? neg_hl : height_ff;
      vcount_in  = req.restart ? '0 : vcount_ff;
      center_in  = req.restart ? '0 : center_ff;
      emit       = 1'b0;
      emit_phase = 16'd0;
      elem_in    = '0;
      hsum       = '0;
      ring_x     = cmg_pkg::IDX_W'(ring_in);
      slc1_x     = cmg_pkg::IDX_W'(slices) + 1'b1;
      j_x        = cmg_pkg::IDX_W'(slice_in);
      rs         = ring_x * slc1_x;
      nrs        = rs + slc1_x;

      case (section_in)
         cmg_pkg::SEC_SIDE_V: begin
            emit = 1'b1;
            if (ring_in == '0 && slice_in == '0) begin
               height_in = neg_hl;
               phase_in  = 16'd0;
            end
            elem_in.kind   = cmg_pkg::KIND_SIDE_VTX;
            elem_in.rim    = 1'b1;
            elem_in.radial = 1'b1;
            elem_in.y      = height_in;
            emit_phase     = phase_in;
            vcount_in      = vcount_in + 1'b1;
            phase_in       = phase_in + cfg.angle_step;
            slice_in       = slice_in + 1'b1;
            if (slice_in >= slices + 1'b1) begin
               slice_in  = '0;
               phase_in  = 16'd0;
               hsum      = {height_in[15], height_in} + $signed({2'b00, cfg.ring_step});
               height_in = (hsum > 17'sd32767) ? 16'sd32767 : hsum[15:0];
               ring_in   = ring_in + 1'b1;
               if (ring_in >= rings) begin
                  ring_in    = '0;
                  section_in = cmg_pkg::SEC_SIDE_T;
               end
            end
         end
         cmg_pkg::SEC_SIDE_T: begin
            emit         = 1'b1;
            elem_in.kind = cmg_pkg::KIND_SIDE_TRI;
            if (!second_in) begin
               elem_in.ia = rs + j_x;
               elem_in.ib = rs + j_x + 1'b1;
               elem_in.ic = nrs + j_x;
               second_in  = 1'b1;
            end else begin
               elem_in.ia = nrs + j_x;
               elem_in.ib = rs + j_x + 1'b1;
               elem_in.ic = nrs + j_x + 1'b1;
               second_in  = 1'b0;
               slice_in   = slice_in + 1'b1;
               if (slice_in >= slices) begin
                  slice_in = '0;
                  ring_in  = ring_in + 1'b1;
                  if (ring_in >= rings - 1'b1) begin
                     ring_in    = '0;
                     section_in = cmg_pkg::SEC_TOP_V;
                  end
               end
            end
         end
         cmg_pkg::SEC_TOP_V, cmg_pkg::SEC_BOT_V: begin
            emit         = 1'b1;
            elem_in.kind = (section_in == cmg_pkg::SEC_TOP_V) ?
                           cmg_pkg::KIND_TOP_VTX : cmg_pkg::KIND_BOT_VTX;
            elem_in.y    = (section_in == cmg_pkg::SEC_TOP_V) ? pos_hl : neg_hl;
            // a zero-height bottom cap still faces up
            elem_in.ny   = (elem_in.y >= 0) ? 16'(cmg_pkg::ONE_Q14) : -16'(cmg_pkg::ONE_Q14);
            if (slice_in == '0) begin
               center_in = vcount_in;
               phase_in  = 16'd0;
            end else begin
               elem_in.rim = 1'b1;
               emit_phase  = phase_in;
               phase_in    = phase_in + cfg.angle_step;
            end
            vcount_in = vcount_in + 1'b1;
            slice_in  = slice_in + 1'b1;
            if (slice_in >= slices + 1'b1) begin
               slice_in   = '0;
               phase_in   = 16'd0;
               section_in = (section_in == cmg_pkg::SEC_TOP_V) ?
                            cmg_pkg::SEC_TOP_T : cmg_pkg::SEC_BOT_T;
            end
         end
         cmg_pkg::SEC_TOP_T, cmg_pkg::SEC_BOT_T: begin
            emit         = 1'b1;
            elem_in.kind = cmg_pkg::KIND_CAP_TRI;
            elem_in.ia   = center_in;
            elem_in.ib   = center_in + j_x + 1'b1;
            // last triangle of the fan wraps to the first rim vertex
            elem_in.ic   = (slice_in + 1'b1 >= slices) ? center_in + 1'b1 :
                           center_in + j_x + 2'd2;
            slice_in     = slice_in + 1'b1;
            if (slice_in >= slices) begin
               slice_in = '0;
               if (section_in == cmg_pkg::SEC_BOT_T) begin
                  elem_in.last = 1'b1;
                  section_in   = cmg_pkg::SEC_DONE;
               end else begin
                  section_in = cmg_pkg::SEC_BOT_V;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      elem_in.cosv = cmg_pkg::sine_of(emit_phase + 16'd16384);
      elem_in.sinv = cmg_pkg::sine_of(emit_phase);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff <= cmg_pkg::SEC_SIDE_V;
         ring_ff    <= '0;
         slice_ff   <= '0;
         second_ff  <= 1'b0;
         phase_ff   <= 16'd0;
         height_ff  <= -16'sd256;
         vcount_ff  <= '0;
         center_ff  <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            section_ff <= section_in;
            ring_ff    <= ring_in;
            slice_ff   <= slice_in;
            second_ff  <= second_in;
            phase_ff   <= phase_in;
            height_ff  <= height_in;
            vcount_ff  <= vcount_in;
            center_ff  <= center_in;
         end
         if (req.ready) begin
            valid_ff <= accept && emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         elem_ff <= elem_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_elem  = elem_ff;

   `CMG_ASSERT_NEXT(a_done_silent, clock, reset, accept && !req.restart && section_ff == cmg_pkg::SEC_DONE, !valid_ff, "finished pass produced a word")
   `CMG_ASSERT_SAME(a_last_done, clock, reset, valid_ff && elem_ff.last, section_ff == cmg_pkg::SEC_DONE, "last word without finished pass")

endmodule

`default_nettype wire

/* design/cmg_datapath.sv */
`default_nettype none

`include "assert_macros.svh"

module cmg_datapath (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [15:0]  radius,
   input  wire logic         stage_valid,
   input  wire cmg_pkg::elem_type stage_elem,
   output logic              stage_ready,
   cmg_rsp_if.source         rsp
);

   logic               valid_ff;
   logic               load;
   logic [2:0]         kind_ff;
   logic signed [15:0] pos_x_ff, pos_x_in;
   logic signed [15:0] pos_y_ff;
   logic signed [15:0] pos_z_ff, pos_z_in;
   logic signed [15:0] norm_x_ff, norm_y_ff, norm_z_ff;
   logic [20:0]        ia_ff, ib_ff, ic_ff;
   logic               last_ff;

   // radius * trig / 2^14, rounded half away from zero, saturated
   function automatic logic signed [15:0] scale_pos(logic [15:0] r, logic signed [15:0] t);
      logic [14:0] mag;
      logic [30:0] full;
      logic [16:0] p;
      mag  = t[15] ? 15'(-t) : t[14:0];
      full = 31'(r * mag) + 31'd8192;
      p    = full[30:14];
      if (t[15]) begin
         return (p > 17'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, p}));
      end
      return (p > 17'd32767) ? 16'sd32767 : p[15:0];
   endfunction

   assign stage_ready = !valid_ff || rsp.ready;
   assign load        = stage_valid && stage_ready;
   assign pos_x_in    = stage_elem.rim ? scale_pos(radius, stage_elem.cosv) : 16'sd0;
   assign pos_z_in    = stage_elem.rim ? scale_pos(radius, stage_elem.sinv) : 16'sd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_ready) begin
         valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= stage_elem.kind;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= stage_elem.y;
         pos_z_ff  <= pos_z_in;
         norm_x_ff <= stage_elem.radial ? stage_elem.cosv : 16'sd0;
         norm_y_ff <= stage_elem.ny;
         norm_z_ff <= stage_elem.radial ? stage_elem.sinv : 16'sd0;
         ia_ff     <= stage_elem.ia;
         ib_ff     <= stage_elem.ib;
         ic_ff     <= stage_elem.ic;
         last_ff   <= stage_elem.last;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.element_kind = kind_ff;
   assign rsp.pos_x        = pos_x_ff;
   assign rsp.pos_y        = pos_y_ff;
   assign rsp.pos_z        = pos_z_ff;
   assign rsp.norm_x       = norm_x_ff;
   assign rsp.norm_y       = norm_y_ff;
   assign rsp.norm_z       = norm_z_ff;
   assign rsp.index_a      = ia_ff;
   assign rsp.index_b      = ib_ff;
   assign rsp.index_c      = ic_ff;
   assign rsp.last         = last_ff;

   `CMG_ASSERT_SAME(a_tri_geom_zero, clock, reset, valid_ff && (kind_ff == cmg_pkg::KIND_SIDE_TRI || kind_ff == cmg_pkg::KIND_CAP_TRI), pos_x_ff == 16'sd0 && pos_z_ff == 16'sd0 && norm_x_ff == 16'sd0 && norm_y_ff == 16'sd0, "triangle carries geometry")
   `CMG_ASSERT_SAME(a_last_cap_tri, clock, reset, valid_ff && last_ff, kind_ff == cmg_pkg::KIND_CAP_TRI, "last set on a word other than a cap triangle")

endmodule

`default_nettype wire

/* design/cylinder_mesh_generator.sv */
`default_nettype none

// Cylinder mesh generator. Every word accepted on req yields at most one mesh element on rsp,
// in this order: side vertices ring by ring (slice_count+1 per ring, radial normals), side
// triangles (two per quad), top cap (center vertex, rim vertices, triangle fan closing on the
// first rim vertex), then the bottom cap the same way; last marks the final bottom cap
// triangle. restart=1 rewinds and emits the first element of a new pass on that same word;
// after the last element, words with restart=0 are taken but produce nothing. Positions are
// signed Q8.8, normals signed Q1.14, sine and cosine come from a constant quarter-wave table.
// Throughput is one word per cycle while rsp takes results: the counters and table lookup sit before a
// stage register, the radius multiply and rounding before the output register; a result passes
// through both registers in turn, and rsp back-pressure stalls req through the two stages.
// Configuration goes through csr_we/csr_index/csr_wdata, one register per cycle, and must only
// be written while no element is in flight.

module cylinder_mesh_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   cmg_req_if.sink          req,
   cmg_rsp_if.source        rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cmg_pkg::cfg_type  cfg;
   cmg_pkg::elem_type stage_elem;
   logic              stage_valid;
   logic              stage_ready;

   // hold the register set
   cmg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // advance the pass counters, pick indices and trig values
   cmg_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req         (req),
      .stage_ready (stage_ready),
      .stage_valid (stage_valid),
      .stage_elem  (stage_elem)
   );

   // scale by radius and drive the result word
   cmg_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .radius      (cfg.radius),
      .stage_valid (stage_valid),
      .stage_elem  (stage_elem),
      .stage_ready (stage_ready),
      .rsp         (rsp)
   );

endmodule

`default_nettype wire

/* dv/cylinder_mesh_generator_test.sv */
`timescale 1ns / 100ps

module cylinder_mesh_generator_test;

   // Predicted mesh element, one per accepted word that produces output.
   typedef struct {
      logic [2:0]         kind;
      logic signed [15:0] px, py, pz, nx, ny, nz;
      logic [20:0]        ia, ib, ic;
      logic               last;
   } mesh_elem_type;

   // Scoreboard: generator state, register copy, table and pending elements.
   class mesh_scoreboard;
      logic [15:0]   radius;
      logic [14:0]   half_length;
      logic [14:0]   ring_step;
      logic [15:0]   angle_step;
      logic [10:0]   ring_count;
      logic [10:0]   slice_count;
      int            section, ring_ctr, slice_ctr;
      bit            second_tri, finished;
      logic [15:0]   phase;
      int            height;
      logic [20:0]   vtx_ctr, cap_center;
      int            qtab[cmg_pkg::SINE_TABLE_DEPTH+1];
      mesh_elem_type pending[$];
      int            errors;
      int            checked;

      function new();
         longint unsigned x, x2, sum, term, q;
         for (int k = 0; k <= cmg_pkg::SINE_TABLE_DEPTH; k++) begin
            x = (64'd1686629713 * k) / cmg_pkg::SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            sum = x;
            term = x;
            for (int n = 1; n <= 12; n++) begin
               term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
               if (n % 2 == 1) sum = (sum >= term) ? sum - term : 0;
               else sum = sum + term;
            end
            q = (sum + 32768) >> 16;
            qtab[k] = (q > 16384) ? 16384 : int'(q);
         end
         radius = 256; half_length = 256; ring_step = 57; angle_step = 2185;
         ring_count = 10; slice_count = 30;
         errors = 0; checked = 0;
         rewind();
      endfunction

      function void rewind();
         section = cmg_pkg::SEC_SIDE_V; ring_ctr = 0; slice_ctr = 0; second_tri = 0;
         phase = 0; height = -int'(half_length); vtx_ctr = 0; cap_center = 0;
         finished = 0;
      endfunction

      function void write_reg(cmg_pkg::csr_index_type idx, logic [15:0] v);
         case (idx)
            cmg_pkg::CSR_RADIUS:      radius = v;
            cmg_pkg::CSR_HALF_LENGTH: half_length = v[14:0];
            cmg_pkg::CSR_RING_STEP:   ring_step = v[14:0];
            cmg_pkg::CSR_ANGLE_STEP:  angle_step = v;
            cmg_pkg::CSR_RING_COUNT:  ring_count = v[10:0];
            cmg_pkg::CSR_SLICE_COUNT: slice_count = v[10:0];
            default: ;
         endcase
      endfunction

      function int sin_q14(logic [15:0] p);
         int i, v;
         i = (int'(p[13:0]) * cmg_pkg::SINE_TABLE_DEPTH) >> 14;
         v = p[14] ? qtab[cmg_pkg::SINE_TABLE_DEPTH - i] : qtab[i];
         return p[15] ? -v : v;
      endfunction

      function int scale(int trig);
         longint unsigned mag, prod;
         mag = (trig < 0) ? -trig : trig;
         prod = (radius * mag + 8192) >> 14;
         if (trig < 0) return (prod > 32768) ? -32768 : -int'(prod);
         return (prod > 32767) ? 32767 : int'(prod);
      endfunction

      function mesh_elem_type vertex(cmg_pkg::kind_type k, bit rim, int y, bit radial,
                                     int ny);
         mesh_elem_type e;
         int c, s;
         c = sin_q14(phase + 16'd16384);
         s = sin_q14(phase);
         e = '{default: 0};
         e.kind = k;
         e.px = rim ? 16'(scale(c)) : 16'sd0;
         e.py = 16'(y);
         e.pz = rim ? 16'(scale(s)) : 16'sd0;
         e.nx = radial ? 16'(c) : 16'sd0;
         e.ny = 16'(ny);
         e.nz = radial ? 16'(s) : 16'sd0;
         vtx_ctr = vtx_ctr + 21'd1;
         return e;
      endfunction

      function mesh_elem_type triangle(cmg_pkg::kind_type k, logic [20:0] a, logic [20:0] b,
                                       logic [20:0] c);
         mesh_elem_type e;
         e = '{default: 0};
         e.kind = k; e.ia = a; e.ib = b; e.ic = c;
         return e;
      endfunction

      // Note an accepted word: advance the generator and queue what it emits.
      function void note_word(bit restart);
         int rings, slices, y, ny, h;
         logic [20:0] rs, nrs;
         mesh_elem_type e;
         if (restart) rewind();
         if (finished || section >= cmg_pkg::SEC_DONE) return;
         rings = (ring_count < 2) ? 2 :
                 (ring_count > cmg_pkg::MAX_RINGS ? cmg_pkg::MAX_RINGS : int'(ring_count));
         slices = (slice_count < 3) ? 3 :
                  (slice_count > cmg_pkg::MAX_SLICES ? cmg_pkg::MAX_SLICES : int'(slice_count));
         case (section)
            cmg_pkg::SEC_SIDE_V: begin
               if (ring_ctr == 0 && slice_ctr == 0) begin
                  height = -int'(half_length);
                  phase = 0;
               end
               e = vertex(cmg_pkg::KIND_SIDE_VTX, 1, height, 1, 0);
               phase = phase + angle_step;
               slice_ctr++;
               if (slice_ctr >= slices + 1) begin
                  slice_ctr = 0;
                  phase = 0;
                  h = height + int'(ring_step);
                  height = (h > 32767) ? 32767 : h;
                  ring_ctr++;
                  if (ring_ctr >= rings) begin
                     ring_ctr = 0;
                     section = cmg_pkg::SEC_SIDE_T;
                  end
               end
            end
            cmg_pkg::SEC_SIDE_T: begin
               rs = 21'(ring_ctr * (slices + 1));
               nrs = rs + 21'(slices + 1);
               if (!second_tri) begin
                  e = triangle(cmg_pkg::KIND_SIDE_TRI, rs + 21'(slice_ctr),
                               rs + 21'(slice_ctr + 1), nrs + 21'(slice_ctr));
                  second_tri = 1;
               end else begin
                  e = triangle(cmg_pkg::KIND_SIDE_TRI, nrs + 21'(slice_ctr),
                               rs + 21'(slice_ctr + 1), nrs + 21'(slice_ctr + 1));
                  second_tri = 0;
                  slice_ctr++;
                  if (slice_ctr >= slices) begin
                     slice_ctr = 0;
                     ring_ctr++;
                     if (ring_ctr >= rings - 1) begin
                        ring_ctr = 0;
                        section = cmg_pkg::SEC_TOP_V;
                     end
                  end
               end
            end
            cmg_pkg::SEC_TOP_V, cmg_pkg::SEC_BOT_V: begin
               y = (section == cmg_pkg::SEC_TOP_V) ? int'(half_length) : -int'(half_length);
               ny = (y >= 0) ? cmg_pkg::ONE_Q14 : -cmg_pkg::ONE_Q14;
               if (slice_ctr == 0) begin
                  cap_center = vtx_ctr;
                  phase = 0;
                  e = vertex(section == cmg_pkg::SEC_TOP_V ? cmg_pkg::KIND_TOP_VTX :
                             cmg_pkg::KIND_BOT_VTX, 0, y, 0, ny);
               end else begin
                  e = vertex(section == cmg_pkg::SEC_TOP_V ? cmg_pkg::KIND_TOP_VTX :
                             cmg_pkg::KIND_BOT_VTX, 1, y, 0, ny);
                  phase = phase + angle_step;
               end
               slice_ctr++;
               if (slice_ctr >= slices + 1) begin
                  slice_ctr = 0;
                  phase = 0;
                  section++;
               end
            end
            default: begin
               e = triangle(cmg_pkg::KIND_CAP_TRI, cap_center,
                            cap_center + 21'(slice_ctr + 1),
                            (slice_ctr + 1 >= slices) ? cap_center + 21'd1 :
                            cap_center + 21'(slice_ctr + 2));
               slice_ctr++;
               if (slice_ctr >= slices) begin
                  slice_ctr = 0;
                  if (section == cmg_pkg::SEC_BOT_T) begin
                     e.last = 1;
                     finished = 1;
                     section = cmg_pkg::SEC_DONE;
                  end else begin
                     section++;
                  end
               end
            end
         endcase
         pending.push_back(e);
      endfunction

      task report(string what, longint got, longint want);
         $display("error: element %0d field %s got %0d expected %0d", checked, what, got, want);
         errors++;
      endtask

      // Compare an accepted element with the oldest prediction.
      task check_elem(mesh_elem_type g);
         mesh_elem_type w;
         if (pending.size() == 0) begin
            report("unpredicted element", 1, 0);
            checked++;
            return;
         end
         w = pending.pop_front();
         if (g.kind !== w.kind) report("element_kind", g.kind, w.kind);
         if (g.px !== w.px) report("pos_x", g.px, w.px);
         if (g.py !== w.py) report("pos_y", g.py, w.py);
         if (g.pz !== w.pz) report("pos_z", g.pz, w.pz);
         if (g.nx !== w.nx) report("norm_x", g.nx, w.nx);
         if (g.ny !== w.ny) report("norm_y", g.ny, w.ny);
         if (g.nz !== w.nz) report("norm_z", g.nz, w.nz);
         if (g.ia !== w.ia) report("index_a", g.ia, w.ia);
         if (g.ib !== w.ib) report("index_b", g.ib, w.ib);
         if (g.ic !== w.ic) report("index_c", g.ic, w.ic);
         if (g.last !== w.last) report("last", g.last, w.last);
         checked++;
      endtask
   endclass

   localparam int STALL_LIMIT = 5000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   cmg_req_if req ();
   cmg_rsp_if rsp ();

   cylinder_mesh_generator i_dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_we, .csr_index, .csr_wdata
   );

   mesh_scoreboard mesh;
   bit             calm;      // suppress random idling on both sides
   int             words_sent;
   int             idle_ctr;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Accept results at the edge, then pick ready for the next cycle.
   initial begin
      rsp.ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            mesh_elem_type g;
            g.kind = rsp.element_kind;
            g.px = rsp.pos_x; g.py = rsp.pos_y; g.pz = rsp.pos_z;
            g.nx = rsp.norm_x; g.ny = rsp.norm_y; g.nz = rsp.norm_z;
            g.ia = rsp.index_a; g.ib = rsp.index_b; g.ic = rsp.index_c;
            g.last = rsp.last;
            mesh.check_elem(g);
         end
         rsp.ready <= calm || ($urandom_range(99) >= 13);
      end
   end

   // Watchdog: count cycles with no word moving on either side.
   initial begin
      idle_ctr = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_ctr = 0;
         else idle_ctr++;
         if (idle_ctr >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("cylinder_mesh_generator: mismatch");
            $finish;
         end
      end
   end

   // Send one word; hold valid until accepted, then maybe drop valid and idle at random.
   task automatic send_word(bit restart);
      req.valid <= 1'b1;
      req.restart <= restart;
      do @(posedge clock); while (!req.ready);
      mesh.note_word(restart);
      words_sent++;
      while (!calm && $urandom_range(99) < 13) begin
         req.valid <= 1'b0;
         req.restart <= 1'($urandom_range(1));
         @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted element is back, plus pipeline drain.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (mesh.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(cmg_pkg::csr_index_type idx, logic [15:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      mesh.write_reg(idx, v);
      csr_we <= 1'b0;
   endtask

   task automatic set_shape(logic [15:0] r, logic [15:0] hl, logic [15:0] rstep,
                            logic [15:0] astep, logic [15:0] rings, logic [15:0] slices);
      write_csr(cmg_pkg::CSR_RADIUS, r);
      write_csr(cmg_pkg::CSR_HALF_LENGTH, hl);
      write_csr(cmg_pkg::CSR_RING_STEP, rstep);
      write_csr(cmg_pkg::CSR_ANGLE_STEP, astep);
      write_csr(cmg_pkg::CSR_RING_COUNT, rings);
      write_csr(cmg_pkg::CSR_SLICE_COUNT, slices);
   endtask

   // Restart, advance until the predictor finishes, then send extra plain words.
   task automatic run_pass(int extra);
      send_word(1'b1);
      while (!mesh.finished) send_word($urandom_range(199) == 0);
      repeat (extra) send_word(1'b0);
   endtask

   initial begin
      mesh = new();
      calm = 0;
      words_sent = 0;
      reset = 1;
      csr_we = 0;
      csr_index = cmg_pkg::CSR_RADIUS;
      csr_wdata = 0;
      req.valid = 0;
      req.restart = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: tiny mesh at extremes, wrap through every section with
      // zero angle step, zero half length (both caps +1 normal), clamped counts.
      set_shape(16'hFFFF, 16'd0, 16'h7FFF, 16'd0, 16'd0, 16'd0);
      run_pass(2);
      drain();
      set_shape(16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd2, 16'd3);
      send_word(1'b0);
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b1);
      drain();
      set_shape(16'h8000, 16'h4000, 16'd1, 16'h4000, 16'h7FF, 16'h7FF);
      repeat (6) send_word(1'b0);
      drain();

      // Random passes or partial runs with small meshes; first one runs without idling.
      for (int p = 0; words_sent < 450; p++) begin
         calm = (p == 0);
         set_shape(16'($urandom), 16'($urandom),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(300)),
                   ($urandom_range(7) == 0) ? 16'($urandom_range(1)) : 16'($urandom),
                   ($urandom_range(5) == 0) ? 16'($urandom_range(3)) :
                   16'($urandom_range(2, 4)),
                   ($urandom_range(5) == 0) ? 16'($urandom_range(4)) :
                   16'($urandom_range(3, 6)));
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 40)) send_word($urandom_range(15) == 0);
         end else begin
            run_pass($urandom_range(3));
         end
         drain();
      end
      calm = 0;

      repeat (20) @(posedge clock);
      $display("covered %0d words and %0d elements over varied shapes, idling and restarts",
               words_sent, mesh.checked);
      if (mesh.errors == 0 && mesh.pending.size() == 0) begin
         $display("cylinder_mesh_generator: match");
      end else begin
         $display("cylinder_mesh_generator: mismatch");
      end
      $finish;
   end
endmodule
